// ===== rtl/svs_pkg.sv =====
`timescale 1ns / 1ps
package svs_pkg;

	localparam int NSLOT = 5;

	// opcodes of an input word
	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_ACTOR = 2'd1;
	localparam logic [1:0] OP_END   = 2'd2;

	// result kinds
	localparam logic [2:0] KIND_OBST        = 3'd0;
	localparam logic [2:0] KIND_FRONT       = 3'd1;
	localparam logic [2:0] KIND_LEFT_FRONT  = 3'd2;
	localparam logic [2:0] KIND_LEFT_REAR   = 3'd3;
	localparam logic [2:0] KIND_RIGHT_FRONT = 3'd4;
	localparam logic [2:0] KIND_RIGHT_REAR  = 3'd5;

	// slot positions
	localparam logic [2:0] SLOT_FRONT       = 3'd0;
	localparam logic [2:0] SLOT_LEFT_FRONT  = 3'd1;
	localparam logic [2:0] SLOT_LEFT_REAR   = 3'd2;
	localparam logic [2:0] SLOT_RIGHT_FRONT = 3'd3;
	localparam logic [2:0] SLOT_RIGHT_REAR  = 3'd4;

	// register indexes (paddr[3:2])
	localparam logic [1:0] REG_LAT_WIN   = 2'd0;
	localparam logic [1:0] REG_LOOKAHEAD = 2'd1;
	localparam logic [1:0] REG_LANE_W    = 2'd2;

	localparam logic [15:0] LAT_WIN_RST   = 16'd384;
	localparam logic [23:0] LOOKAHEAD_RST = 24'd25600;
	localparam logic [15:0] LANE_W_RST    = 16'd896;

	localparam logic signed [31:0] GAP_EMPTY   = 32'sh7FFF_FFFF;
	localparam logic signed [15:0] ANGLE_LIMIT = 16'sd21845;  // 120 degrees
	localparam logic signed [33:0] DS_MIN      = -34'sd2560;  // -10 m behind

	typedef logic signed [31:0] gap_t;

	// last member sits in the lowest bits, so vehicle_id is s_tdata[15:0]
	typedef struct packed {
		logic [15:0]        veh_width;
		logic signed [23:0] veh_speed;
		logic [15:0]        veh_length;
		logic signed [7:0]  lane;
		logic signed [31:0] t_pos;
		logic signed [31:0] s_pos;
		logic [15:0]        road;
		logic signed [15:0] heading;
		logic [15:0]        vehicle_id;
	} item_t;

	typedef struct packed {
		logic [15:0]        id;
		logic signed [15:0] heading;
		logic [15:0]        road;
		logic signed [7:0]  lane;
		logic signed [31:0] s_pos;
		logic signed [31:0] t_pos;
		logic [15:0]        len;
	} ego_t;

	typedef struct packed {
		logic [15:0] lateral_window;
		logic [23:0] lookahead;
		logic [15:0] lane_width;
	} cfg_t;

	// verdict on one actor
	typedef struct packed {
		logic               keep;
		logic [NSLOT-1:0]   take;
		logic signed [31:0] slot_gap;
		logic signed [31:0] dt;
	} eval_t;

	typedef struct packed {
		logic [2:0]         kind;
		logic               present;
		logic [15:0]        actor_index;
		logic signed [31:0] out_s;
		logic signed [31:0] out_d;
		logic signed [31:0] gap;
		logic signed [23:0] out_speed;
		logic [15:0]        out_length;
		logic [15:0]        out_width;
		logic               is_last;
	} res_t;

endpackage

// ===== rtl/surrounding_vehicle_selector.sv =====
`timescale 1ns / 1ps
// an input word is registered in stage 1, then its result word in the output register
// one input word per cycle unless held; load, actor and spare opcodes retire as they fire
// end of scan holds stage 1 until it has put out one word per slot; the input waits
// a stalled result word holds a stage 1 word that needs the output, and the input side
// reset: arst_n clears ego, counters, slots and config to defaults at once
// no clearing pass: the five slots reset in flip-flops
module surrounding_vehicle_selector #(
	parameter int MAX_OBST = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	// input words
	input  logic         s_tvalid,
	output logic         s_tready,
	// vehicle_id, heading, road, s_pos, t_pos, lane, veh_length, veh_speed, veh_width
	input  logic [175:0] s_tdata,
	// opcode
	input  logic [1:0]   s_tuser,
	// result words
	output logic         m_tvalid,
	input  logic         m_tready,
	// present, actor_index, out_s, out_d, gap, out_speed, out_length, out_width, 7 pad
	output logic [175:0] m_tdata,
	// kind
	output logic [2:0]   m_tuser,
	output logic         m_tlast,
	// config port
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);
	import svs_pkg::*;

	localparam int OBST_W = $clog2(MAX_OBST + 1);

	// config registers
	cfg_t cfg_q;

	// input stage
	logic        valid_s1;
	logic [1:0]  op_s1;
	item_t       item_s1;

	// scan state
	ego_t              ego_q;
	logic [15:0]       actor_cnt_q;
	logic [OBST_W-1:0] obst_cnt_q;
	logic [2:0]        slot_cnt_q;     // next slot word during end of scan
	logic [NSLOT-1:0]  slot_present_q;
	logic [15:0]       slot_index_q   [NSLOT];
	gap_t [NSLOT-1:0]  slot_gap_q;
	logic signed [23:0] slot_speed_q  [NSLOT];
	logic signed [31:0] slot_lateral_q[NSLOT];

	// output register
	logic  out_valid_q;
	res_t  res_q;
	res_t  res_d;

	eval_t ev;
	logic  obst_room;
	logic  needs_out;
	logic  out_free;
	logic  fire;
	logic  done;
	logic  cfg_wr;

	// ------------------------------------------------------------------
	// config port: write on the access cycle, zero wait states
	// ------------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lateral_window <= LAT_WIN_RST;
			cfg_q.lookahead      <= LOOKAHEAD_RST;
			cfg_q.lane_width     <= LANE_W_RST;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_LAT_WIN:   cfg_q.lateral_window <= pwdata[15:0];
				REG_LOOKAHEAD: cfg_q.lookahead      <= pwdata[23:0];
				REG_LANE_W:    cfg_q.lane_width     <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_LAT_WIN:   prdata = {16'd0, cfg_q.lateral_window};
			REG_LOOKAHEAD: prdata = {8'd0, cfg_q.lookahead};
			REG_LANE_W:    prdata = {16'd0, cfg_q.lane_width};
			default:       prdata = 32'd0;
		endcase
	end

	// ------------------------------------------------------------------
	// actor evaluation against the held ego and the current slots
	// ------------------------------------------------------------------
	svs_eval u_eval (
		.item     (item_s1),
		.ego      (ego_q),
		.cfg      (cfg_q),
		.slot_gap (slot_gap_q),
		.res      (ev)
	);

	assign obst_room = obst_cnt_q < OBST_W'(MAX_OBST);

	// does the word in stage 1 put a word on the output this cycle
	always_comb begin
		unique case (op_s1)
			OP_ACTOR: needs_out = ev.keep && obst_room;
			OP_END:   needs_out = 1'b1;
			default:  needs_out = 1'b0;
		endcase
	end

	assign out_free = !out_valid_q || m_tready;
	assign fire     = valid_s1 && (!needs_out || out_free);
	// end of scan stays in stage 1 until its last slot word is put into the output register
	assign done     = fire && !(op_s1 == OP_END && slot_cnt_q != SLOT_RIGHT_REAR);
	assign s_tready = !valid_s1 || done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1   <= s_tuser;
			item_s1 <= item_t'(s_tdata);
		end
	end

	// ------------------------------------------------------------------
	// scan state update when stage 1 retires a step
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ego_q          <= '0;
			actor_cnt_q    <= '0;
			obst_cnt_q     <= '0;
			slot_cnt_q     <= '0;
			slot_present_q <= '0;
			for (int k = 0; k < NSLOT; k++) begin
				slot_index_q[k]   <= '0;
				slot_gap_q[k]     <= GAP_EMPTY;
				slot_speed_q[k]   <= '0;
				slot_lateral_q[k] <= '0;
			end
		end else if (fire) begin
			unique case (op_s1)
				OP_LOAD: begin
					ego_q.id       <= item_s1.vehicle_id;
					ego_q.heading  <= item_s1.heading;
					ego_q.road     <= item_s1.road;
					ego_q.lane     <= item_s1.lane;
					ego_q.s_pos    <= item_s1.s_pos;
					ego_q.t_pos    <= item_s1.t_pos;
					ego_q.len      <= item_s1.veh_length;
					actor_cnt_q    <= '0;
					obst_cnt_q     <= '0;
					slot_present_q <= '0;
					for (int k = 0; k < NSLOT; k++) begin
						slot_index_q[k]   <= '0;
						slot_gap_q[k]     <= GAP_EMPTY;
						slot_speed_q[k]   <= '0;
						slot_lateral_q[k] <= '0;
					end
				end
				OP_ACTOR: begin
					// dropped actors still advance the index
					actor_cnt_q <= actor_cnt_q + 16'd1;
					if (needs_out)
						obst_cnt_q <= obst_cnt_q + OBST_W'(1);
					for (int k = 0; k < NSLOT; k++) begin
						if (ev.take[k]) begin
							slot_present_q[k] <= 1'b1;
							slot_index_q[k]   <= actor_cnt_q;
							slot_gap_q[k]     <= ev.slot_gap;
							slot_speed_q[k]   <= item_s1.veh_speed;
							slot_lateral_q[k] <= ev.dt;
						end
					end
				end
				OP_END: begin
					slot_cnt_q <= (slot_cnt_q == SLOT_RIGHT_REAR) ? SLOT_FRONT
						: slot_cnt_q + 3'd1;
				end
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// next result word: obstacle or one slot
	// ------------------------------------------------------------------
	always_comb begin
		if (op_s1 == OP_END) begin
			res_d.kind        = slot_cnt_q + 3'd1;
			res_d.present     = slot_present_q[slot_cnt_q];
			res_d.actor_index = slot_index_q[slot_cnt_q];
			res_d.out_s       = '0;
			res_d.out_d       = slot_lateral_q[slot_cnt_q];
			res_d.gap         = slot_gap_q[slot_cnt_q];
			res_d.out_speed   = slot_speed_q[slot_cnt_q];
			res_d.out_length  = '0;
			res_d.out_width   = '0;
			res_d.is_last     = (slot_cnt_q == SLOT_RIGHT_REAR);
		end else begin
			res_d.kind        = KIND_OBST;
			res_d.present     = 1'b1;
			res_d.actor_index = actor_cnt_q;
			res_d.out_s       = item_s1.s_pos;
			res_d.out_d       = item_s1.t_pos;
			res_d.gap         = '0;
			res_d.out_speed   = item_s1.veh_speed;
			res_d.out_length  = item_s1.veh_length;
			res_d.out_width   = item_s1.veh_width;
			res_d.is_last     = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && needs_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && needs_out)
			res_q <= res_d;
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = res_q.kind;
	assign m_tlast  = res_q.is_last;
	assign m_tdata  = {7'd0, res_q.out_width, res_q.out_length, res_q.out_speed,
		res_q.gap, res_q.out_d, res_q.out_s, res_q.actor_index, res_q.present};

endmodule

// ===== rtl/svs_eval.sv =====
`timescale 1ns / 1ps
module svs_eval (
	input  svs_pkg::item_t                   item,
	input  svs_pkg::ego_t                    ego,
	input  svs_pkg::cfg_t                    cfg,
	input  svs_pkg::gap_t [svs_pkg::NSLOT-1:0] slot_gap,
	output svs_pkg::eval_t                   res
);
	import svs_pkg::*;

	logic signed [15:0] hd_diff;
	logic               ang_ok;
	logic signed [32:0] ds_raw;
	logic signed [33:0] ds;
	logic               long_ok;
	logic signed [32:0] dt;
	logic [32:0]        abs_dt;
	logic [18:0]        lim_a;
	logic [18:0]        lim_b;
	logic [18:0]        lim;
	logic               lat_ok;
	logic [16:0]        len_sum;
	logic signed [35:0] g2;
	logic signed [35:0] gap36;
	logic signed [31:0] gap;
	logic signed [31:0] neg_gap;
	logic               gap_pos;
	logic               gap_neg;
	logic signed [8:0]  loff;
	logic signed [36:0] dt10;
	logic [17:0]        lw3;
	logic signed [36:0] lw3_s;
	logic               front_zone;
	logic               left_zone;
	logic               right_zone;

	always_comb begin
		// heading difference wraps as a binary angle
		hd_diff = item.heading - ego.heading;
		ang_ok  = !(hd_diff > ANGLE_LIMIT || hd_diff < -ANGLE_LIMIT);

		ds_raw = {item.s_pos[31], item.s_pos} - {ego.s_pos[31], ego.s_pos};
		if (!ego.lane[7] && ego.lane != 8'sd0)
			ds = -{ds_raw[32], ds_raw};
		else
			ds = {ds_raw[32], ds_raw};
		long_ok = (ds <= $signed({10'd0, cfg.lookahead})) && (ds >= DS_MIN);

		dt     = {item.t_pos[31], item.t_pos} - {ego.t_pos[31], ego.t_pos};
		abs_dt = dt[32] ? 33'(-dt) : 33'(dt);
		lim_a  = {cfg.lateral_window, 3'b000};
		lim_b  = {cfg.lane_width, 3'b000} - {3'b000, cfg.lane_width};
		lim    = (lim_a > lim_b) ? lim_a : lim_b;
		lat_ok = {abs_dt, 1'b0} <= {15'd0, lim};

		res.keep = (item.vehicle_id != ego.id) && ang_ok && (item.road == ego.road)
			&& long_ok && lat_ok;

		// floor of half the doubled bumper gap
		len_sum = {1'b0, ego.len} + {1'b0, item.veh_length};
		g2      = {{1{ds[33]}}, ds, 1'b0} - $signed({19'd0, len_sum});
		gap36   = g2 >>> 1;
		gap     = gap36[31:0];
		neg_gap = -gap;
		gap_pos = !gap[31] && (gap != 32'sd0);
		gap_neg = gap[31];

		loff  = {item.lane[7], item.lane} - {ego.lane[7], ego.lane};
		dt10  = ({{4{dt[32]}}, dt} <<< 3) + ({{4{dt[32]}}, dt} <<< 1);
		lw3   = {1'b0, cfg.lane_width, 1'b0} + {2'b00, cfg.lane_width};
		lw3_s = $signed({19'd0, lw3});

		front_zone = (loff == 9'sd0) && (abs_dt < {17'd0, cfg.lateral_window});
		left_zone  = (loff > 9'sd0) || (dt10 > lw3_s);
		right_zone = (loff < 9'sd0) || (dt10 < -lw3_s);

		res.take = '0;
		if (res.keep) begin
			if (front_zone) begin
				res.take[SLOT_FRONT] = gap_pos && (gap < slot_gap[SLOT_FRONT]);
			end else if (left_zone) begin
				res.take[SLOT_LEFT_FRONT] = gap_pos && (gap < slot_gap[SLOT_LEFT_FRONT]);
				res.take[SLOT_LEFT_REAR]  = gap_neg && (neg_gap < slot_gap[SLOT_LEFT_REAR]);
			end else if (right_zone) begin
				res.take[SLOT_RIGHT_FRONT] = gap_pos && (gap < slot_gap[SLOT_RIGHT_FRONT]);
				res.take[SLOT_RIGHT_REAR]  = gap_neg && (neg_gap < slot_gap[SLOT_RIGHT_REAR]);
			end
		end
		// rear slots keep the magnitude
		res.slot_gap = gap_neg ? neg_gap : gap;
		res.dt       = dt[31:0];
	end

endmodule

// ===== rtl/svs_checker.sv =====
`timescale 1ns / 1ps
module svs_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [175:0] m_tdata,
	input logic [2:0]   m_tuser,
	input logic         m_tlast
);
	import svs_pkg::*;

	// a stalled word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result word changed while stalled");

	// only the right rear slot closes a scan
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser == KIND_RIGHT_REAR)
		else $error("last flag on a word other than right rear");

	// obstacle words always carry present and no gap
	a_obst: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_OBST |-> m_tdata[0] && m_tdata[112:81] == 32'd0)
		else $error("obstacle word malformed");

	// the left front slot word follows a taken front slot word back to back
	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tuser == KIND_FRONT |=>
			m_tvalid && m_tuser == KIND_LEFT_FRONT)
		else $error("slot words out of order");

endmodule

bind surrounding_vehicle_selector svs_checker u_svs_checker (.*);
